// ----- hw/rtl/keyed_min_max_aggregation_table_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the keyed min/max aggregation table.
// Each macro expands to one labelled concurrent assertion on clock; only KMM_ASSERT_SAME is disabled by reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_MIN_MAX_AGGREGATION_TABLE_ASSERT_SVH
`define KEYED_MIN_MAX_AGGREGATION_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMM_ASSERT_SAME(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KMM_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/kmm_pkg.sv -----
// ----------------------------------------------------------------------------
// kmm_pkg
// Types and constants shared by the keyed min/max aggregation table.
// ----------------------------------------------------------------------------
package kmm_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_ENTRY   = 2'd1;
   localparam logic [1:0] KIND_EXTRACT = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   localparam logic CSR_TAKE_MAX       = 1'b0;
   localparam logic CSR_VALUE_IS_FLOAT = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic               map_null;
      logic signed [63:0] entry_key;
      logic               key_null;
      logic signed [63:0] entry_value;
      logic               value_null;
   } req_type;

   typedef struct packed {
      logic signed [63:0] out_key;
      logic signed [63:0] out_value;
      logic               last;
      logic               is_empty;
      logic               group_null;
      logic               overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_EXT_RD,
      ST_EXT_OUT,
      ST_SINGLE
   } state_type;

endpackage

// ----- hw/rtl/keyed_min_max_aggregation_table.sv -----
// ----------------------------------------------------------------------------
// keyed_min_max_aggregation_table
// Table of key and value pairs keeping the minimum or maximum value per key.
// ----------------------------------------------------------------------------
//   channel   ports                              direction
//   request   req_valid, req_ready, req_data     in
//   response  rsp_valid, rsp_ready, rsp_data     out
//   csr       csr_we, csr_index, csr_wdata       in
//
// A header or ignored item is handled in idle. An entry searches each stored
// slot in turn (read, then compare) through the single key/value memory port,
// and goes straight to the compare when the table is empty.
// An extract reads and sends each result in turn, or sends a single result.
// Reset clears the fill count and flags; the memory needs no clearing.
// A stalled response holds the extract until the output register frees.

module keyed_min_max_aggregation_table
   #(parameter int TABLE_ENTRIES = kmm_pkg::TABLE_ENTRIES_DEFAULT)
   (input  logic             clock,
    input  logic             reset,
    input  logic             req_valid,
    output logic             req_ready,
    input  kmm_pkg::req_type req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output kmm_pkg::rsp_type rsp_data,
    input  logic             csr_we,
    input  logic             csr_index,
    input  logic             csr_wdata);

   import kmm_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

   logic [63:0] mem_key [TABLE_ENTRIES];
   logic [63:0] mem_val [TABLE_ENTRIES];

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               group_ff, group_in;
   logic               ovf_ff, ovf_in;
   logic               take_max_ff, is_float_ff;
   logic [63:0]        key_ff, key_in, val_ff, val_in;
   logic [63:0]        rd_key_ff, rd_val_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept, entry_ok, is_nan, out_free;
   logic               hit, scan_end, wr_en, keep_stored, new_less, old_less;
   logic [IDX_W-1:0]   wr_addr;
   logic [63:0]        wr_val;
   logic [CNT_W-1:0]   idx_next;

   function automatic logic val_less(input logic [63:0] a, input logic [63:0] b,
                                     input logic fl);
      logic [63:0] ka, kb;
      logic        a_nan, b_nan;
      ka = a[63] ? ~a : (a ^ SIGN64);
      kb = b[63] ? ~b : (b ^ SIGN64);
      a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
      b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
      if (fl) begin
         return !a_nan && !b_nan && !((a[62:0] == 63'd0) && (b[62:0] == 63'd0))
                && (ka < kb);
      end
      return (a ^ SIGN64) < (b ^ SIGN64);
   endfunction

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_nan   = is_float_ff && (req_data.entry_value[62:52] == 11'h7ff)
                     && (req_data.entry_value[51:0] != 52'd0);
   assign entry_ok = !req_data.key_null && !req_data.value_null && !is_nan;
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign hit      = (count_ff != '0) && (rd_key_ff == key_ff);
   assign scan_end = (count_ff == '0) || (idx_next == count_ff);
   assign new_less = val_less(val_ff, rd_val_ff, is_float_ff);
   assign old_less = val_less(rd_val_ff, val_ff, is_float_ff);
   assign keep_stored = take_max_ff ? new_less : old_less;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      group_in     = group_ff;
      ovf_in       = ovf_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_val       = val_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               key_in = req_data.entry_key;
               val_in = req_data.entry_value;
               priority if (req_data.kind == KIND_HEADER) begin
                  if (!req_data.map_null) begin
                     group_in = 1'b1;
                  end
               end else if (req_data.kind == KIND_ENTRY) begin
                  if (entry_ok) begin
                     state_in = (count_ff == '0) ? ST_SCAN_CMP : ST_SCAN_RD;
                  end
               end else if (req_data.kind == KIND_EXTRACT) begin
                  state_in = (!group_ff || count_ff == '0) ? ST_SINGLE : ST_EXT_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (hit) begin
               wr_en    = 1'b1;
               wr_val   = keep_stored ? rd_val_ff : val_ff;
               state_in = ST_IDLE;
            end else if (scan_end) begin
               state_in = ST_IDLE;
               if (count_ff != CNT_W'(TABLE_ENTRIES)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_EXT_RD: begin
            state_in = ST_EXT_OUT;
         end
         ST_EXT_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_key   = rd_key_ff;
               rsp_in.out_value = rd_val_ff;
               rsp_in.last      = (idx_next == count_ff);
               rsp_in.is_empty  = 1'b0;
               rsp_in.group_null = 1'b0;
               rsp_in.overflow  = ovf_ff;
               if (idx_next == count_ff) begin
                  state_in = ST_IDLE;
                  count_in = '0;
                  group_in = 1'b0;
                  ovf_in   = 1'b0;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_EXT_RD;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.out_key    = '0;
               rsp_in.out_value  = '0;
               rsp_in.last       = 1'b1;
               rsp_in.is_empty   = 1'b1;
               rsp_in.group_null = !group_ff;
               rsp_in.overflow   = ovf_ff;
               state_in = ST_IDLE;
               count_in = '0;
               group_in = 1'b0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_key[wr_addr] <= key_ff;
         mem_val[wr_addr] <= wr_val;
      end
      rd_key_ff <= mem_key[idx_ff];
      rd_val_ff <= mem_val[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         group_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         take_max_ff  <= 1'b0;
         is_float_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         group_ff     <= group_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TAKE_MAX:       take_max_ff <= csr_wdata;
               CSR_VALUE_IS_FLOAT: is_float_ff <= csr_wdata;
               default:            take_max_ff <= take_max_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      key_ff <= key_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ----- hw/rtl/kmm_checker.sv -----
// ----------------------------------------------------------------------------
// kmm_checker
// Port-level checks on the keyed min/max aggregation table.
// ----------------------------------------------------------------------------
`include "keyed_min_max_aggregation_table_assert.svh"

module kmm_checker
   (input logic             clock,
    input logic             reset,
    input logic             req_valid,
    input logic             req_ready,
    input kmm_pkg::req_type req_data,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input kmm_pkg::rsp_type rsp_data);

   import kmm_pkg::*;

   `KMM_ASSERT_NEXT(a_reset_idle, reset, !rsp_valid && req_ready)
   `KMM_ASSERT_SAME(a_empty_last, rsp_valid && rsp_data.is_empty, rsp_data.last)
   `KMM_ASSERT_SAME(a_null_empty, rsp_valid && rsp_data.group_null, rsp_data.is_empty)
   `KMM_ASSERT_NEXT(a_rsp_hold, !reset && rsp_valid && !rsp_ready,
                    reset || (rsp_valid && $stable(rsp_data)))

endmodule

bind keyed_min_max_aggregation_table kmm_checker u_kmm_checker (.*);
